/* rtl/mgj_pkg.sv */
// Shared types, constants and helpers for the Gauss-Jordan matrix inverter.
// Used by mgj_div, mgj_msu and matrix_inverse_gauss_jordan.
`timescale 1ns / 1ps
`default_nettype none

package mgj_pkg;

  localparam int WORD_W    = 32;
  localparam int Q_FRAC    = 16;
  localparam int DIV_STEPS = WORD_W + Q_FRAC;

  localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [WORD_W-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] S_MIN = 32'sh8000_0000;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic {
    SEL_WORK = 1'b0,
    SEL_INV  = 1'b1
  } mem_sel_t;

  typedef enum logic {
    REG_DIM    = 1'b0,
    REG_THRESH = 1'b1
  } reg_idx_t;

  // Tag that travels with an operation through the multiply unit.
  typedef struct packed {
    logic     valid;
    mem_sel_t sel;
  } msu_tag_t;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [WORD_W-1:0] mag32(input word_t v);
    logic [WORD_W-1:0] u;
    begin
      u = v;
      mag32 = v[WORD_W-1] ? (~u + 32'd1) : u;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/mgj_div.sv */
// Bit-serial Q16.16 divider: (|a|<<16 + |d|/2) / |d|, sign restored, saturated.
// One quotient bit per cycle; depends on mgj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgj_div
  import mgj_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          start,
  input  word_t        num,
  input  word_t        den,
  output logic         done,
  output word_t        quo
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic                   busy;
  logic                   fin;
  logic [CNT_W-1:0]       cnt;
  logic [DIV_STEPS-1:0]   nsh;
  logic [WORD_W-1:0]      rem;
  logic [WORD_W-1:0]      dm;
  logic [DIV_STEPS-1:0]   q;
  logic                   neg;

  logic [WORD_W-1:0]      dm_in;
  logic [DIV_STEPS-1:0]   nm_in;
  logic [WORD_W:0]        rem_t;
  logic                   take;

  assign dm_in = mag32(den);
  assign nm_in = {mag32(num), {Q_FRAC{1'b0}}} + {{(Q_FRAC + 1){1'b0}}, dm_in[WORD_W-1:1]};
  assign rem_t = {rem, nsh[DIV_STEPS-1]};
  assign take  = rem_t >= {1'b0, dm};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
        nsh  <= nm_in;
        dm   <= dm_in;
        rem  <= '0;
        q    <= '0;
        neg  <= num[WORD_W-1] ^ den[WORD_W-1];
      end else if (busy) begin
        nsh <= {nsh[DIV_STEPS-2:0], 1'b0};
        rem <= take ? WORD_W'(rem_t - {1'b0, dm}) : rem_t[WORD_W-1:0];
        q   <= {q[DIV_STEPS-2:0], take};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
        if (!neg) begin
          quo <= (q > DIV_STEPS'(S_MAX)) ? S_MAX : q[WORD_W-1:0];
        end else begin
          quo <= (q > DIV_STEPS'(64'h8000_0000)) ? S_MIN : (~q[WORD_W-1:0] + 32'd1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/mgj_msu.sv */
// Three-stage multiply-subtract unit: y = sat(x - round(f*b >> 16)).
// Product, rounding and subtract each have a register; depends on mgj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgj_msu
  import mgj_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  msu_tag_t     tag_in,
  input  word_t        f,
  input  word_t        b,
  input  word_t        x,
  output msu_tag_t     tag_out,
  output word_t        y
);

  localparam int PW = 2 * WORD_W;
  localparam int RW = PW - Q_FRAC;

  msu_tag_t              t1, t2;
  logic signed [PW-1:0]  p1;
  word_t                 x1, x2;
  logic signed [RW:0]    r2;

  logic [PW-1:0]         pm;
  logic [PW-1:0]         pr;
  logic signed [RW:0]    rs;
  logic signed [RW+1:0]  diff;

  always_comb begin
    pm   = p1[PW-1] ? (~p1 + PW'(1)) : p1;
    pr   = pm + PW'(32768);
    rs   = p1[PW-1] ? -$signed({1'b0, pr[PW-1:Q_FRAC]}) : $signed({1'b0, pr[PW-1:Q_FRAC]});
    diff = $signed({{(RW + 2 - WORD_W){x2[WORD_W-1]}}, x2}) - $signed({r2[RW], r2});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1      <= '0;
      t2      <= '0;
      tag_out <= '0;
    end else begin
      t1      <= tag_in;
      t2      <= t1;
      tag_out <= t2;
    end
    p1 <= f * b;
    x1 <= x;
    r2 <= rs;
    x2 <= x1;
    // saturate when the upper bits are not a sign extension
    if (diff[RW+1:WORD_W-1] != {(RW + 3 - WORD_W){diff[RW+1]}}) begin
      y <= diff[RW+1] ? S_MIN : S_MAX;
    end else begin
      y <= diff[WORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/matrix_inverse_gauss_jordan.sv */
// Gauss-Jordan matrix inverter with partial pivoting, signed Q16.16; one matrix at a time.
// Loading takes one transfer per cycle while s_tvalid is high, for n*n entries; then
// s_tready stays low until the last result transfer. Inversion writes the identity,
// then per column c searches the pivot, swaps rows when needed, divides each pivot-row
// entry of both matrices and eliminates the other rows with the shared multiply unit;
// output entries wait on m_tready. Sync reset: control idle, dim 4, threshold 1.
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_gauss_jordan
  import mgj_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire  [0:0]   cfg_index,
  input  wire  [15:0]  cfg_data,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [31:0]  s_tdata,   // entry
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [31:0]  m_tdata,   // inverse_entry
  output logic [0:0]   m_tuser,   // singular
  output logic         m_tlast
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int LCW   = AW + 1;
  localparam int CW    = LCW + 2 * NW;

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT, ST_PS_RD, ST_PS_CMP, ST_PS_CHK,
    ST_SW_RD1, ST_SW_RD2, ST_SW_WR1, ST_SW_WR2,
    ST_DV_RD, ST_DV_LAT, ST_DV_WAIT_W, ST_DV_WAIT_I,
    ST_EL_ROW, ST_EL_F_RD, ST_EL_F, ST_EL_RD1, ST_EL_RD2, ST_EL_MUL1, ST_EL_MUL2,
    ST_EL_WAIT, ST_COL, ST_OUT_RD, ST_OUT_LAT, ST_OUT_HOLD
  } state_t;

  state_t          state;
  logic [3:0]      dim;
  logic [15:0]     thresh;
  logic [LCW-1:0]  lc;
  logic [NW-1:0]   n;
  logic [RW-1:0]   r, c, j, p;
  word_t           best, piv, fct, pw, pi, tw, ti, ai;

  word_t           wmem [DEPTH];
  word_t           imem [DEPTH];
  word_t           w_rdata, i_rdata;

  logic [NW-1:0]   eff_n;
  logic [LCW-1:0]  lc_next;
  logic [NW-1:0]   n_m1;
  logic            last_r, last_j;
  logic [RW-1:0]   rd_row, rd_col, wr_row, wr_col;
  logic [AW-1:0]   raddr, waddr;
  logic            w_we, i_we;
  word_t           w_wdata, i_wdata;
  logic            s_fire;

  logic            div_start, div_done;
  word_t           div_num, div_q;
  msu_tag_t        msu_in, msu_out;
  word_t           msu_b, msu_x, msu_y;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [RW-1:0] col,
                                              input logic [NW-1:0] nn);
    logic [RW+NW-1:0] prod;
    begin
      prod      = row * nn;
      cell_addr = AW'(prod + (RW + NW)'(col));
    end
  endfunction

  always_comb begin
    if (dim == 4'd0) begin
      eff_n = NW'(1);
    end else if (dim > 4'(MAX_DIM)) begin
      eff_n = NW'(MAX_DIM);
    end else begin
      eff_n = dim[NW-1:0];
    end
  end

  assign s_tready = (state == ST_LOAD);
  assign s_fire   = s_tvalid && s_tready;
  assign lc_next  = lc + LCW'(1);
  assign n_m1     = n - NW'(1);
  assign last_r   = (NW'(r) == n_m1);
  assign last_j   = (NW'(j) == n_m1);

  // read row/column select
  always_comb begin
    rd_row = r;
    rd_col = j;
    case (state)
      ST_PS_RD, ST_EL_F_RD: rd_col = c;
      ST_DV_RD, ST_EL_RD1, ST_SW_RD2: rd_row = c;
      ST_SW_RD1: rd_row = p;
      default: ;
    endcase
    raddr = cell_addr(rd_row, rd_col, n);
  end

  always_comb begin
    wr_row = r;
    wr_col = j;
    case (state)
      ST_SW_WR1: wr_row = p;
      ST_SW_WR2, ST_DV_WAIT_W, ST_DV_WAIT_I: wr_row = c;
      default: ;
    endcase
    waddr = (state == ST_LOAD) ? lc[AW-1:0] : cell_addr(wr_row, wr_col, n);
  end

  always_comb begin
    w_we    = 1'b0;
    i_we    = 1'b0;
    w_wdata = msu_y;
    i_wdata = msu_y;
    case (state)
      ST_LOAD: begin
        w_we    = s_fire && (lc < LCW'(DEPTH));
        w_wdata = s_tdata;
      end
      ST_INIT: begin
        i_we    = 1'b1;
        i_wdata = (r == j) ? Q_ONE : '0;
      end
      ST_SW_WR1: begin
        w_we    = 1'b1;
        i_we    = 1'b1;
        w_wdata = w_rdata;
        i_wdata = i_rdata;
      end
      ST_SW_WR2: begin
        w_we    = 1'b1;
        i_we    = 1'b1;
        w_wdata = tw;
        i_wdata = ti;
      end
      ST_DV_WAIT_W: begin
        w_we    = div_done;
        w_wdata = div_q;
      end
      ST_DV_WAIT_I: begin
        i_we    = div_done;
        i_wdata = div_q;
      end
      default: begin
        w_we = msu_out.valid && (msu_out.sel == SEL_WORK);
        i_we = msu_out.valid && (msu_out.sel == SEL_INV);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[waddr] <= w_wdata;
    end
    if (i_we) begin
      imem[waddr] <= i_wdata;
    end
    w_rdata <= wmem[raddr];
    i_rdata <= imem[raddr];
  end

  assign div_start = (state == ST_DV_LAT) || ((state == ST_DV_WAIT_W) && div_done);
  assign div_num   = (state == ST_DV_LAT) ? w_rdata : ai;

  mgj_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (piv),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    msu_in.valid = (state == ST_EL_MUL1) || (state == ST_EL_MUL2);
    msu_in.sel   = (state == ST_EL_MUL2) ? SEL_INV : SEL_WORK;
    msu_b        = (state == ST_EL_MUL2) ? pi : pw;
    msu_x        = (state == ST_EL_MUL2) ? ti : w_rdata;
  end

  mgj_msu u_msu (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (msu_in),
    .f       (fct),
    .b       (msu_b),
    .x       (msu_x),
    .tag_out (msu_out),
    .y       (msu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      dim      <= 4'd4;
      thresh   <= 16'd1;
      lc       <= '0;
      n        <= NW'(1);
      r        <= '0;
      c        <= '0;
      j        <= '0;
      p        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIM:    dim    <= cfg_data[3:0];
          REG_THRESH: thresh <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_LOAD: begin
          if (s_fire) begin
            if (CW'(lc_next) >= CW'(eff_n * eff_n)) begin
              lc    <= '0;
              n     <= eff_n;
              r     <= '0;
              j     <= '0;
              state <= ST_INIT;
            end else begin
              lc <= lc_next;
            end
          end
        end
        ST_INIT: begin
          if (last_j) begin
            j <= '0;
            if (last_r) begin
              r     <= '0;
              c     <= '0;
              state <= ST_PS_RD;
            end else begin
              r <= r + RW'(1);
            end
          end else begin
            j <= j + RW'(1);
          end
        end
        ST_PS_RD: state <= ST_PS_CMP;
        ST_PS_CMP: begin
          if ((r == c) || (mag32(w_rdata) > mag32(best))) begin
            best <= w_rdata;
            p    <= r;
          end
          if (last_r) begin
            state <= ST_PS_CHK;
          end else begin
            r     <= r + RW'(1);
            state <= ST_PS_RD;
          end
        end
        ST_PS_CHK: begin
          if ((best == '0) || (mag32(best) < {16'd0, thresh})) begin
            m_tdata  <= '0;
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            m_tvalid <= 1'b1;
            state    <= ST_OUT_HOLD;
          end else begin
            piv   <= best;
            j     <= '0;
            state <= (p == c) ? ST_DV_RD : ST_SW_RD1;
          end
        end
        ST_SW_RD1: state <= ST_SW_RD2;
        ST_SW_RD2: begin
          tw    <= w_rdata;
          ti    <= i_rdata;
          state <= ST_SW_WR1;
        end
        ST_SW_WR1: state <= ST_SW_WR2;
        ST_SW_WR2: begin
          if (last_j) begin
            j     <= '0;
            state <= ST_DV_RD;
          end else begin
            j     <= j + RW'(1);
            state <= ST_SW_RD1;
          end
        end
        ST_DV_RD: state <= ST_DV_LAT;
        ST_DV_LAT: begin
          ai    <= i_rdata;
          state <= ST_DV_WAIT_W;
        end
        ST_DV_WAIT_W: begin
          if (div_done) begin
            state <= ST_DV_WAIT_I;
          end
        end
        ST_DV_WAIT_I: begin
          if (div_done) begin
            if (last_j) begin
              j     <= '0;
              r     <= '0;
              state <= ST_EL_ROW;
            end else begin
              j     <= j + RW'(1);
              state <= ST_DV_RD;
            end
          end
        end
        ST_EL_ROW: begin
          if (r == c) begin
            if (last_r) begin
              state <= ST_COL;
            end else begin
              r <= r + RW'(1);
            end
          end else begin
            state <= ST_EL_F_RD;
          end
        end
        ST_EL_F_RD: state <= ST_EL_F;
        ST_EL_F: begin
          fct   <= w_rdata;
          j     <= '0;
          state <= ST_EL_RD1;
        end
        ST_EL_RD1: state <= ST_EL_RD2;
        ST_EL_RD2: begin
          pw    <= w_rdata;
          pi    <= i_rdata;
          state <= ST_EL_MUL1;
        end
        ST_EL_MUL1: begin
          ti    <= i_rdata;
          state <= ST_EL_MUL2;
        end
        ST_EL_MUL2: state <= ST_EL_WAIT;
        ST_EL_WAIT: begin
          // advance once the inverse-side result is written
          if (msu_out.valid && (msu_out.sel == SEL_INV)) begin
            if (last_j) begin
              j <= '0;
              if (last_r) begin
                state <= ST_COL;
              end else begin
                r     <= r + RW'(1);
                state <= ST_EL_ROW;
              end
            end else begin
              j     <= j + RW'(1);
              state <= ST_EL_RD1;
            end
          end
        end
        ST_COL: begin
          if (NW'(c) == n_m1) begin
            r     <= '0;
            j     <= '0;
            state <= ST_OUT_RD;
          end else begin
            c     <= c + RW'(1);
            r     <= c + RW'(1);
            state <= ST_PS_RD;
          end
        end
        ST_OUT_RD: state <= ST_OUT_LAT;
        ST_OUT_LAT: begin
          m_tdata  <= i_rdata;
          m_tuser  <= 1'b0;
          m_tlast  <= last_r && last_j;
          m_tvalid <= 1'b1;
          state    <= ST_OUT_HOLD;
        end
        ST_OUT_HOLD: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= ST_LOAD;
            end else begin
              if (last_j) begin
                j <= '0;
                r <= r + RW'(1);
              end else begin
                j <= j + RW'(1);
              end
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the Gauss-Jordan matrix inverter, signed Q16.16.
// Needs mgj_pkg and matrix_inverse_gauss_jordan; predicts every inverse in-bench.
`timescale 1ns / 1ps

module tb_top;
  import mgj_pkg::*;

  localparam int  STORE_N    = 64;
  localparam int  CYCLE_CAP  = 2_000_000;
  localparam int  SETTLE     = 200;

  typedef struct {
    logic [31:0] entry;
    logic        singular;
    logic        last;
  } inv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // inverse_entry
  logic [0:0]  m_tuser;   // singular
  logic        m_tlast;

  inv_result_t pending_inv[$];
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          hold_cnt = 0;
  bit          quiet_mode = 1'b0;

  // shadow of the block state
  longint      shadow_work[STORE_N];
  longint      shadow_inv[STORE_N];
  int          shadow_loaded = 0;
  logic [3:0]  shadow_dim = 4'd4;
  logic [15:0] shadow_thresh = 16'd1;

  matrix_inverse_gauss_jordan i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("FAIL matrix_inverse_gauss_jordan");
      $finish;
    end
  end

  // ---------------- fixed-point predictor ----------------
  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs_val(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    longint r;
    p = a * b;
    r = (abs_val(p) + 32768) >>> 16;
    return (p < 0) ? -r : r;
  endfunction

  function automatic longint fx_div(longint a, longint d);
    longint dm;
    longint q;
    dm = abs_val(d);
    q = ((abs_val(a) <<< 16) + (dm >>> 1)) / dm;
    if ((a < 0) != (d < 0)) q = -q;
    return sat_word(q);
  endfunction

  function automatic void swap_shadow_rows(int n, int a, int b);
    longint t;
    for (int j = 0; j < n; j++) begin
      t = shadow_work[a*n+j]; shadow_work[a*n+j] = shadow_work[b*n+j]; shadow_work[b*n+j] = t;
      t = shadow_inv[a*n+j];  shadow_inv[a*n+j]  = shadow_inv[b*n+j];  shadow_inv[b*n+j]  = t;
    end
  endfunction

  // Gauss-Jordan on the shadow stores; returns 0 when a pivot is too small
  function automatic bit eliminate(int n);
    int     p;
    longint piv;
    longint f;
    for (int r = 0; r < n; r++)
      for (int j = 0; j < n; j++)
        shadow_inv[r*n+j] = (r == j) ? 64'sd65536 : 64'sd0;
    for (int c = 0; c < n; c++) begin
      p = c;
      for (int r = c + 1; r < n; r++)
        if (abs_val(shadow_work[r*n+c]) > abs_val(shadow_work[p*n+c])) p = r;
      piv = shadow_work[p*n+c];
      if (piv == 0 || abs_val(piv) < longint'(shadow_thresh)) return 1'b0;
      swap_shadow_rows(n, p, c);
      for (int j = 0; j < n; j++) begin
        shadow_work[c*n+j] = fx_div(shadow_work[c*n+j], piv);
        shadow_inv[c*n+j]  = fx_div(shadow_inv[c*n+j], piv);
      end
      for (int r = 0; r < n; r++) begin
        if (r == c) continue;
        f = shadow_work[r*n+c];
        for (int j = 0; j < n; j++) begin
          shadow_work[r*n+j] = sat_word(shadow_work[r*n+j] - fx_mul(f, shadow_work[c*n+j]));
          shadow_inv[r*n+j]  = sat_word(shadow_inv[r*n+j] - fx_mul(f, shadow_inv[c*n+j]));
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void queue_result(inv_result_t res);
    pending_inv.insert(pending_inv.size(), res);
  endfunction

  function automatic void load_entry(logic [31:0] v);
    int          n;
    inv_result_t res;
    n = (shadow_dim == 0) ? 1 : (shadow_dim > 8) ? 8 : int'(shadow_dim);
    if (shadow_loaded < STORE_N) shadow_work[shadow_loaded] = longint'($signed(v));
    shadow_loaded = (shadow_loaded + 1) & 8'h7f;
    if (shadow_loaded < n*n) return;
    shadow_loaded = 0;
    if (!eliminate(n)) begin
      res.entry = '0; res.singular = 1'b1; res.last = 1'b1;
      queue_result(res);
      return;
    end
    for (int k = 0; k < n*n; k++) begin
      res.entry = shadow_inv[k][31:0];
      res.singular = 1'b0;
      res.last = (k == n*n - 1);
      queue_result(res);
    end
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      m_tready <= quiet_mode || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin
    inv_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_inv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: data %h singular %b last %b", m_tdata, m_tuser, m_tlast);
      end else begin
        want = pending_inv.pop_front();
        if (m_tdata !== want.entry || m_tuser[0] !== want.singular || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%b/%b got %h/%b/%b", want.entry, want.singular,
                     want.last, m_tdata, m_tuser, m_tlast);
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_entry(logic [31:0] v);
    // idle a random number of cycles, about 29 in a hundred overall
    while (!quiet_mode && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    load_entry(v);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_inv.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DIM) shadow_dim = val[3:0];
    else shadow_thresh = val;
  endtask

  function automatic logic [31:0] pick_entry(int noise_pct);
    int v;
    if ($urandom_range(99) < noise_pct) return $urandom;
    v = int'($urandom_range(0, 8*65536)) - 4*65536;
    return v;
  endfunction

  // ---------------- tests ----------------
  task automatic test_scalar_edges();
    write_reg(REG_THRESH, 16'd0);
    write_reg(REG_DIM, 16'd1);
    send_entry(32'h0000_0000);   // zero pivot is singular even at threshold 0
    send_entry(32'h0001_0000);
    send_entry(32'h7fff_ffff);
    send_entry(32'h8000_0000);
    send_entry(32'h0000_0001);   // quotient saturates
    send_entry(32'hffff_ffff);
    drain();
    write_reg(REG_THRESH, 16'hffff);
    send_entry(32'h0000_fffe);   // just under threshold
    drain();
    write_reg(REG_DIM, 16'd0);   // behaves as order 1
    send_entry(32'h0002_0000);
    drain();
  endtask

  task automatic test_pivot_choice();
    write_reg(REG_THRESH, 16'd1);
    write_reg(REG_DIM, 16'd2);
    // equal magnitudes in column 0: top row wins
    send_entry(32'h0001_0000); send_entry(32'h0002_0000);
    send_entry(32'hffff_0000); send_entry(32'h0003_0000);
    // dependent rows: second pivot vanishes
    send_entry(32'h0001_0000); send_entry(32'h0002_0000);
    send_entry(32'h0002_0000); send_entry(32'h0004_0000);
    drain();
  endtask

  task automatic test_dim_change_mid_load();
    write_reg(REG_DIM, 16'd3);
    for (int i = 0; i < 5; i++) send_entry(pick_entry(0));
    s_tvalid <= 1'b0;
    repeat (20) @(posedge clk);
    write_reg(REG_DIM, 16'd2);   // count already past 4: next entry starts the run
    send_entry(pick_entry(0));
    drain();
  endtask

  task automatic test_random(int order, int mats, int noise_pct, bit pause_between);
    write_reg(REG_DIM, 16'(order));
    for (int m = 0; m < mats; m++) begin
      for (int k = 0; k < (order == 0 ? 1 : order > 8 ? 64 : order*order); k++)
        send_entry(pick_entry(noise_pct));
      if (pause_between && m[0]) drain();
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_DIM, 16'd3);
    for (int k = 0; k < 9; k++) send_entry(pick_entry(0));
    hold_cnt = 3000;
    // keep offering the next matrix while results are held back
    for (int k = 0; k < 18; k++) send_entry(pick_entry(5));
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_scalar_edges();
    test_pivot_choice();
    test_dim_change_mid_load();
    write_reg(REG_THRESH, 16'd1);
    test_random(2, 6, 15, 1'b1);
    write_reg(REG_THRESH, 16'(int'($urandom_range(0, 65535))));
    test_random(3, 4, 15, 1'b0);
    quiet_mode = 1'b1;
    write_reg(REG_THRESH, 16'd16);
    test_random(4, 2, 10, 1'b0);
    quiet_mode = 1'b0;
    test_backpressure();
    write_reg(REG_THRESH, 16'd0);
    test_random(15, 1, 0, 1'b0);   // clamps to order 8
    write_reg(REG_THRESH, 16'hffff);
    test_random(2, 2, 0, 1'b0);
    if (mismatches == 0) begin
      $display("PASS matrix_inverse_gauss_jordan");
    end else begin
      $display("FAIL matrix_inverse_gauss_jordan");
    end
    $finish;
  end

endmodule
